// ===== src/slc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the source line comment classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       line_end;
	} slc_item_t;

	typedef struct packed {
		logic [1:0] line_class;
		logic       in_block_comment;
	} slc_result_t;

	localparam logic [1:0] CLASS_EMPTY        = 2'd0;
	localparam logic [1:0] CLASS_COMMENT      = 2'd1;
	localparam logic [1:0] CLASS_CODE_COMMENT = 2'd2;
	localparam logic [1:0] CLASS_CODE         = 2'd3;

	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

endpackage
`default_nettype wire

// ===== src/slc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_front
// Scans one character per cycle while the queue is not full, tracks tags and
// whitespace positions of the line and classifies it on its last request.
// ----------------------------------------------------------------------------
module slc_front
	import slc_pkg::*;
#(
	parameter int MAX_LINE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire slc_item_t   item,
	input  wire logic        queue_full,
	output logic             full,
	output logic             res_push,
	output slc_result_t      res_data
);

	localparam int POS_W = $clog2(MAX_LINE);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'd32) || (c == 8'd9) || (c == 8'd10) ||
			(c == 8'd11) || (c == 8'd12) || (c == 8'd13);
	endfunction

	logic             comment_open_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       prev_q;
	logic             seen_q;
	logic [POS_W-1:0] first_q;
	logic [POS_W-1:0] last_q;
	logic             ltag_q;
	logic [POS_W-1:0] ltag_pos_q;
	logic             btag_q;
	logic [POS_W-1:0] btag_pos_q;

	logic [POS_W-1:0] pos_n, first_n, last_n, ltag_pos_n, btag_pos_n, start;
	logic [7:0]       prev_n;
	logic             seen_n, ltag_n, btag_n, block_hit, accept, whole;
	logic [1:0]       cls;
	logic             open_after;

	assign full   = queue_full;
	assign accept = push && !full;
	assign start  = (pos_q != '0) ? pos_q - 1'b1 : '0;

	always_comb begin
		pos_n      = pos_q;
		prev_n     = prev_q;
		seen_n     = seen_q;
		first_n    = first_q;
		last_n     = last_q;
		ltag_n     = ltag_q;
		ltag_pos_n = ltag_pos_q;
		btag_n     = btag_q;
		btag_pos_n = btag_pos_q;
		block_hit  = 1'b0;
		if (item.has_char) begin
			if (!is_space(item.char_code)) begin
				if (!seen_q) begin
					seen_n  = 1'b1;
					first_n = pos_q;
				end
				last_n = pos_q;
			end
			if (comment_open_q) begin
				block_hit = (prev_q == CH_STAR) && (item.char_code == CH_SLASH);
			end else begin
				block_hit = (prev_q == CH_SLASH) && (item.char_code == CH_STAR);
			end
			if (block_hit && !btag_q) begin
				btag_n     = 1'b1;
				btag_pos_n = start;
			end
			if ((prev_q == CH_SLASH) && (item.char_code == CH_SLASH) && !ltag_q) begin
				ltag_n     = 1'b1;
				ltag_pos_n = start;
			end
			prev_n = item.char_code;
			if (pos_q != POS_LAST) begin
				pos_n = pos_q + 1'b1;
			end
		end
	end

	// line classification on the updated line state
	always_comb begin
		open_after = comment_open_q;
		whole      = 1'b0;
		if (!seen_n) begin
			cls = CLASS_EMPTY;
		end else if (btag_n) begin
			if (comment_open_q) begin
				whole = ({1'b0, btag_pos_n} + 1'b1) == {1'b0, last_n};
			end else begin
				whole = (btag_pos_n == first_n);
			end
			cls        = whole ? CLASS_COMMENT : CLASS_CODE_COMMENT;
			open_after = !comment_open_q;
		end else if (comment_open_q) begin
			cls = CLASS_COMMENT;
		end else if (ltag_n) begin
			cls = (ltag_pos_n == first_n) ? CLASS_COMMENT : CLASS_CODE_COMMENT;
		end else begin
			cls = CLASS_CODE;
		end
	end

	assign res_push                  = accept && item.line_end;
	assign res_data.line_class       = cls;
	assign res_data.in_block_comment = open_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_open_q <= 1'b0;
			pos_q          <= '0;
			prev_q         <= '0;
			seen_q         <= 1'b0;
			first_q        <= '0;
			last_q         <= '0;
			ltag_q         <= 1'b0;
			ltag_pos_q     <= '0;
			btag_q         <= 1'b0;
			btag_pos_q     <= '0;
		end else if (accept) begin
			if (item.line_end) begin
				comment_open_q <= open_after;
				pos_q          <= '0;
				prev_q         <= '0;
				seen_q         <= 1'b0;
				first_q        <= '0;
				last_q         <= '0;
				ltag_q         <= 1'b0;
				ltag_pos_q     <= '0;
				btag_q         <= 1'b0;
				btag_pos_q     <= '0;
			end else begin
				pos_q      <= pos_n;
				prev_q     <= prev_n;
				seen_q     <= seen_n;
				first_q    <= first_n;
				last_q     <= last_n;
				ltag_q     <= ltag_n;
				ltag_pos_q <= ltag_pos_n;
				btag_q     <= btag_n;
				btag_pos_q <= btag_pos_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/slc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_queue
// Short first-in first-out queue of line results between front and back.
// ----------------------------------------------------------------------------
module slc_queue
	import slc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire slc_result_t wr_data,
	output logic             full,
	output logic             rd_valid,
	input  wire logic        rd_en,
	output slc_result_t      rd_data
);

	slc_result_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_wr, do_rd;

	assign full     = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/slc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_back
// Output register that presents the oldest line result to the consumer.
// ----------------------------------------------------------------------------
module slc_back
	import slc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	input  wire slc_result_t src_data,
	output logic             take,
	output logic             empty,
	input  wire logic        pop,
	output slc_result_t      result
);

	logic        valid_q;
	slc_result_t data_q;

	assign take   = src_valid && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = data_q;

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== src/source_line_comment_classifier_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_line_comment_classifier_core
// Classifies source lines as empty, comment, code with comment or code.
// A line-ending result goes through the result queue into the output register.
// Throughput: one character request per cycle; full rises only while the
// four-entry result queue is full.
// Reset: arst_n clears the comment state, line state, queue and output valid flag.
// ----------------------------------------------------------------------------
module source_line_comment_classifier_core
	import slc_pkg::*;
#(
	parameter int MAX_LINE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire slc_item_t   item,
	output logic             empty,
	input  wire logic        pop,
	output slc_result_t      result
);

	logic        queue_full, res_push, q_valid, q_take;
	slc_result_t res_data, q_data;

	slc_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.queue_full(queue_full),
		.full      (full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	slc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (queue_full),
		.rd_valid(q_valid),
		.rd_en   (q_take),
		.rd_data (q_data)
	);

	slc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(q_valid),
		.src_data (q_data),
		.take     (q_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
`default_nettype wire

// ===== src/slc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the classifier core, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker
	import slc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire slc_item_t   item,
	input wire logic        empty,
	input wire logic        pop,
	input wire slc_result_t result
);

	logic line_acc;
	assign line_acc = push && !full && item.line_end;

	// no result before reset ends
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// an accepted line-ending request leads to a shown result
	a_line_result: assert property (@(posedge clk) disable iff (!arst_n)
		line_acc |=> ##1 !empty)
		else $error("line result missing");

	// no result without a line-ending request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && $past(empty) && !line_acc && !$past(line_acc)) |=> empty)
		else $error("result without line end");

	// waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind source_line_comment_classifier_core slc_checker u_slc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.item  (item),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
`default_nettype wire

// ===== tb/source_line_comment_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_line_comment_classifier_core_tb
// Streams source text requests into the line classifier and checks each line
// class and the open block comment flag against a cycle-free line predictor.
// Uses a short line limit so that saturated positions occur often, random
// push and pop gaps, and full/empty back pressure from the result queue.
// ----------------------------------------------------------------------------
module source_line_comment_classifier_core_tb;
	import slc_pkg::*;

	localparam int LINE_LIMIT = 32;
	localparam int REQ_TARGET = 1700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        push = 1'b0;
	logic        full;
	slc_item_t   item = '0;
	logic        empty;
	logic        pop = 1'b0;
	slc_result_t result;

	slc_item_t   char_req_q[$];
	slc_result_t line_expect_q[$];

	int sent_cnt = 0;
	int line_cnt = 0;
	int comment_line_cnt = 0;
	int fail_cnt = 0;

	// line predictor state
	logic       blk_open = 1'b0;
	int         col = 0;
	logic [7:0] prev_byte = '0;
	logic       has_text = 1'b0;
	int         text_first = 0;
	int         text_last = 0;
	logic       slash_seen = 1'b0;
	int         slash_col = 0;
	logic       tag_seen = 1'b0;
	int         tag_col = 0;

	source_line_comment_classifier_core #(
		.MAX_LINE(LINE_LIMIT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	function automatic logic is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic calm_stretch();
		return sent_cnt >= 700 && sent_cnt < 1000;
	endfunction

	task automatic track_line_request(slc_item_t req);
		int          start;
		logic        hit;
		slc_result_t res;
		if (req.has_char) begin
			start = (col > 0) ? col - 1 : 0;
			if (!is_blank(req.char_code)) begin
				if (!has_text) begin
					has_text = 1'b1;
					text_first = col;
				end
				text_last = col;
			end
			if (blk_open)
				hit = prev_byte == CH_STAR && req.char_code == CH_SLASH;
			else
				hit = prev_byte == CH_SLASH && req.char_code == CH_STAR;
			if (hit && !tag_seen) begin
				tag_seen = 1'b1;
				tag_col = start;
			end
			if (prev_byte == CH_SLASH && req.char_code == CH_SLASH && !slash_seen) begin
				slash_seen = 1'b1;
				slash_col = start;
			end
			prev_byte = req.char_code;
			if (col < LINE_LIMIT - 1)
				col++;
		end
		if (req.line_end) begin
			if (!has_text) begin
				res.line_class = CLASS_EMPTY;
			end else if (tag_seen) begin
				if (blk_open)
					res.line_class = (tag_col + 1 == text_last) ? CLASS_COMMENT : CLASS_CODE_COMMENT;
				else
					res.line_class = (tag_col == text_first) ? CLASS_COMMENT : CLASS_CODE_COMMENT;
				blk_open = ~blk_open;
			end else if (blk_open) begin
				res.line_class = CLASS_COMMENT;
			end else if (slash_seen) begin
				res.line_class = (slash_col == text_first) ? CLASS_COMMENT : CLASS_CODE_COMMENT;
			end else begin
				res.line_class = CLASS_CODE;
			end
			res.in_block_comment = blk_open;
			line_expect_q.push_back(res);
			col = 0;
			prev_byte = '0;
			has_text = 1'b0;
			text_first = 0;
			text_last = 0;
			slash_seen = 1'b0;
			slash_col = 0;
			tag_seen = 1'b0;
			tag_col = 0;
		end
	endtask

	task automatic queue_req(logic [7:0] c, logic has, logic fin);
		slc_item_t req;
		req.char_code = c;
		req.has_char = has;
		req.line_end = fin;
		char_req_q.push_back(req);
	endtask

	// request driver
	always @(posedge clk) begin
		logic taken;
		if (arst_n) begin
			taken = push && !full;
			if (taken) begin
				track_line_request(item);
				void'(char_req_q.pop_front());
				sent_cnt++;
			end
			if (push && !taken) begin
				// hold the request until accepted
			end else if (char_req_q.size() != 0 && (calm_stretch() || $urandom_range(99) >= 28)) begin
				push <= 1'b1;
				item <= char_req_q[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		slc_result_t exp_res;
		if (arst_n) begin
			if (pop && !empty) begin
				if (line_expect_q.size() == 0) begin
					$error("unexpected result class=%0d open=%0d",
						result.line_class, result.in_block_comment);
					fail_cnt++;
				end else begin
					exp_res = line_expect_q.pop_front();
					line_cnt++;
					if (exp_res.line_class == CLASS_COMMENT)
						comment_line_cnt++;
					if (result.line_class !== exp_res.line_class) begin
						$error("line_class expected %0d actual %0d",
							exp_res.line_class, result.line_class);
						fail_cnt++;
					end
					if (result.in_block_comment !== exp_res.in_block_comment) begin
						$error("in_block_comment expected %0d actual %0d",
							exp_res.in_block_comment, result.in_block_comment);
						fail_cnt++;
					end
				end
			end
			pop <= calm_stretch() || $urandom_range(99) >= 28;
		end
	end

	initial begin
		logic [7:0] line_bytes[$];
		logic [7:0] c;
		int         n_tok;
		int         n_req;
		int         k;
		int         run;
		logic       end_on_char;

		// empty line, character code ignored
		queue_req(8'h55, 1'b0, 1'b1);
		// opening tag starts the line
		queue_req(CH_SLASH, 1'b1, 1'b0);
		queue_req(CH_STAR, 1'b1, 1'b1);
		// inside block comment, no closing tag
		queue_req("x", 1'b1, 1'b1);
		// closing tag followed by code
		queue_req(CH_STAR, 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b0);
		queue_req("y", 1'b1, 1'b1);
		// code then line comment
		queue_req("a", 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b1);
		// idle request
		queue_req(8'hff, 1'b0, 1'b0);
		// line comment only
		queue_req(CH_SLASH, 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b1);
		// zero byte is code
		queue_req(8'h00, 1'b1, 1'b1);
		// whitespace only
		queue_req(8'h09, 1'b1, 1'b0);
		queue_req(8'h0a, 1'b1, 1'b0);
		queue_req(8'h0b, 1'b1, 1'b0);
		queue_req(8'h0c, 1'b1, 1'b0);
		queue_req(8'h0d, 1'b1, 1'b0);
		queue_req(8'h20, 1'b1, 1'b1);
		// code then opening tag
		queue_req("c", 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b0);
		queue_req(CH_STAR, 1'b1, 1'b1);
		// closing tag ends the line
		queue_req(8'h20, 1'b1, 1'b0);
		queue_req(CH_STAR, 1'b1, 1'b0);
		queue_req(CH_SLASH, 1'b1, 1'b1);

		n_req = char_req_q.size();
		while (n_req < REQ_TARGET) begin
			line_bytes.delete();
			n_tok = ($urandom_range(9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 6);
			for (int t = 0; t < n_tok; t++) begin
				k = $urandom_range(0, 11);
				case (k)
					0: begin
						line_bytes.push_back(CH_SLASH);
						line_bytes.push_back(CH_STAR);
					end
					1: begin
						line_bytes.push_back(CH_STAR);
						line_bytes.push_back(CH_SLASH);
					end
					2: begin
						line_bytes.push_back(CH_SLASH);
						line_bytes.push_back(CH_SLASH);
					end
					3: begin
						run = $urandom_range(1, 3);
						for (int i = 0; i < run; i++) begin
							c = ($urandom_range(1) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
							line_bytes.push_back(c);
						end
					end
					4: line_bytes.push_back(CH_SLASH);
					5: line_bytes.push_back(CH_STAR);
					6: line_bytes.push_back(8'($urandom_range(255)));
					default: begin
						run = $urandom_range(1, 4);
						for (int i = 0; i < run; i++)
							line_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
					end
				endcase
			end
			end_on_char = line_bytes.size() != 0 && $urandom_range(1) == 1;
			foreach (line_bytes[i]) begin
				if ($urandom_range(19) == 0)
					queue_req(8'($urandom_range(255)), 1'b0, 1'b0);
				queue_req(line_bytes[i], 1'b1, end_on_char && i == line_bytes.size() - 1);
				n_req++;
			end
			if (!end_on_char) begin
				queue_req(8'($urandom_range(255)), 1'b0, 1'b1);
				n_req++;
			end
		end

		// falling edge so the asynchronous reset takes effect at once
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (char_req_q.size() != 0 || push)
			@(posedge clk);
		while (line_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("streamed %0d requests forming %0d classified lines", sent_cnt, line_cnt);
		$display("%0d lines were comment only, line limit %0d", comment_line_cnt, LINE_LIMIT);
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(12 * 300000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
src/slc_pkg.sv
src/slc_front.sv
src/slc_queue.sv
src/slc_back.sv
src/source_line_comment_classifier_core.sv
src/slc_checker.sv
tb/source_line_comment_classifier_core_tb.sv
